>>> hw/rtl/bmp_pixel_row_unpacker_top_defines.svh
// Assertion macros used by the pixel row unpacker checker.
`ifndef BMP_PIXEL_ROW_UNPACKER_TOP_DEFINES_SVH
`define BMP_PIXEL_ROW_UNPACKER_TOP_DEFINES_SVH

// Checked only while out of reset.
`define BPRU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpru assertion failed");

// Checked at every edge, reset included.
`define BPRU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bpru assertion failed");

`endif

>>> hw/rtl/bpru_pkg.sv
// Types, constants and helpers for the pixel row unpacker.
package bpru_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_IDX_W     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [12:0] MAX_WIDTH = 13'd4096;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH) + 1;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

    localparam logic [31:0] MASK_B3 = 32'hFF000000;
    localparam logic [31:0] MASK_B2 = 32'h00FF0000;
    localparam logic [31:0] MASK_B1 = 32'h0000FF00;

    typedef enum logic [1:0] {
        OP_PAL_LOAD  = 2'd0,
        OP_PIXEL     = 2'd1,
        OP_NEW_IMAGE = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        REG_BPP        = 3'd0,
        REG_ROW_WIDTH  = 3'd1,
        REG_RED_MASK   = 3'd2,
        REG_GREEN_MASK = 3'd3,
        REG_BLUE_MASK  = 3'd4,
        REG_ALPHA_MASK = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        K_PAL_WR = 3'd0,
        K_IDX1   = 3'd1,
        K_IDX4   = 3'd2,
        K_IDX8   = 3'd3,
        K_RGB16  = 3'd4,
        K_RGB24  = 3'd5,
        K_RGB32  = 3'd6
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] entry_alpha;
    } item_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
        logic       row_end;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [5:0]  bits_per_pixel;
        logic [12:0] row_width;
        logic [31:0] red_mask;
        logic [31:0] green_mask;
        logic [31:0] blue_mask;
        logic [31:0] alpha_mask;
    } cfg_t;

    // data: palette color {r,g,b,a}, raw byte in [7:0], or the gathered word
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] data;
        logic [7:0]  index;
        logic [3:0]  npix;
        logic        row_end;
    } cmd_t;

    function automatic logic [7:0] field_of(input logic [31:0] word, input logic [31:0] m);
        logic [31:0] wm;
        logic [7:0]  f;
        wm = word & m;
        if (m == MASK_B3)
            f = wm[31:24];
        else if (m == MASK_B2)
            f = wm[23:16];
        else if (m == MASK_B1)
            f = wm[15:8];
        else
            f = wm[7:0];
        return f;
    endfunction

endpackage

>>> hw/rtl/bpru_front.sv
// Front end: takes input items, tracks row/padding/gather state, issues commands.
module bpru_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bpru_pkg::item_t   item,
    input  bpru_pkg::cfg_t    cfg,
    input  logic              q_full,
    output logic              cmd_valid,
    output bpru_pkg::cmd_t    cmd
);

    logic [23:0] gather_reg, gather_next;
    logic [1:0]  phase_reg, phase_next;
    logic [12:0] col_reg, col_next;
    logic [1:0]  rbp_reg, rbp_next;
    logic [1:0]  pad_reg, pad_next;

    logic        accept;
    logic        bpp_ok;
    logic        is_sub;
    logic [3:0]  per;
    logic [2:0]  need;
    logic [1:0]  need_m1;
    logic [12:0] w_eff;
    logic [13:0] col_p1;
    logic        hit;
    logic [12:0] rem;
    logic        ends;
    logic [3:0]  npix;
    logic [1:0]  rbp_inc;
    logic        gathering;
    logic [31:0] gather_sh;
    logic [31:0] byte_sh;
    logic [23:0] lowmask;
    logic [31:0] word;
    bpru_pkg::cmd_kind_t kind;

    assign accept = push && !q_full;

    always_comb
    begin
        bpp_ok = 1'b1;
        is_sub = 1'b0;
        per    = 4'd1;
        need   = 3'd1;
        kind   = bpru_pkg::K_IDX8;
        case (cfg.bits_per_pixel)
            6'd1:
            begin
                is_sub = 1'b1;
                per    = 4'd8;
                kind   = bpru_pkg::K_IDX1;
            end
            6'd4:
            begin
                is_sub = 1'b1;
                per    = 4'd2;
                kind   = bpru_pkg::K_IDX4;
            end
            6'd8:
            begin
                is_sub = 1'b1;
                kind   = bpru_pkg::K_IDX8;
            end
            6'd16:
            begin
                need = 3'd2;
                kind = bpru_pkg::K_RGB16;
            end
            6'd24:
            begin
                need = 3'd3;
                kind = bpru_pkg::K_RGB24;
            end
            6'd32:
            begin
                need = 3'd4;
                kind = bpru_pkg::K_RGB32;
            end
            default:
            begin
                bpp_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cfg.row_width == 13'd0)
            w_eff = 13'd1;
        else if (cfg.row_width > bpru_pkg::MAX_WIDTH)
            w_eff = bpru_pkg::MAX_WIDTH;
        else
            w_eff = cfg.row_width;
    end

    assign col_p1    = {1'b0, col_reg} + 14'd1;
    assign hit       = col_p1 >= {1'b0, w_eff};
    assign rem       = hit ? 13'd1 : (w_eff - col_reg);
    assign ends      = rem <= {9'd0, per};
    assign npix      = ends ? rem[3:0] : per;
    assign rbp_inc   = rbp_reg + 2'd1;
    assign gathering = !is_sub && (({1'b0, phase_reg} + 3'd1) < need);
    assign need_m1   = 2'(need - 3'd1);
    assign gather_sh = 32'(item.data_byte) << {phase_reg, 3'b000};
    assign byte_sh   = 32'(item.data_byte) << {need_m1, 3'b000};

    always_comb
    begin
        case (need)
            3'd2:    lowmask = 24'h0000FF;
            3'd3:    lowmask = 24'h00FFFF;
            default: lowmask = 24'hFFFFFF;
        endcase
    end

    assign word = {8'd0, gather_reg & lowmask} | byte_sh;

    always_comb
    begin
        gather_next = gather_reg;
        phase_next  = phase_reg;
        col_next    = col_reg;
        rbp_next    = rbp_reg;
        pad_next    = pad_reg;
        cmd_valid   = 1'b0;
        cmd.kind    = kind;
        cmd.data    = is_sub ? {24'd0, item.data_byte} : word;
        cmd.index   = item.entry_index;
        cmd.npix    = is_sub ? npix : 4'd1;
        cmd.row_end = ends;
        if (accept)
        begin
            case (item.opcode)
                bpru_pkg::OP_PAL_LOAD:
                begin
                    cmd_valid = 1'b1;
                    cmd.kind  = bpru_pkg::K_PAL_WR;
                    cmd.data  = {item.entry_red, item.entry_green,
                                 item.entry_blue, item.entry_alpha};
                end
                bpru_pkg::OP_NEW_IMAGE:
                begin
                    gather_next = '0;
                    phase_next  = '0;
                    col_next    = '0;
                    rbp_next    = '0;
                    pad_next    = '0;
                end
                bpru_pkg::OP_PIXEL:
                begin
                    if (bpp_ok)
                    begin
                        if (pad_reg != 2'd0)
                        begin
                            pad_next = pad_reg - 2'd1;
                        end
                        else
                        begin
                            rbp_next = rbp_inc;
                            if (gathering)
                            begin
                                gather_next = gather_reg | gather_sh[23:0];
                                phase_next  = phase_reg + 2'd1;
                            end
                            else
                            begin
                                cmd_valid   = 1'b1;
                                gather_next = '0;
                                phase_next  = '0;
                                if (ends)
                                begin
                                    col_next = '0;
                                    pad_next = 2'd0 - rbp_inc;
                                    rbp_next = '0;
                                end
                                else
                                begin
                                    col_next = col_reg + 13'(per);
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= '0;
            phase_reg  <= '0;
            col_reg    <= '0;
            rbp_reg    <= '0;
            pad_reg    <= '0;
        end
        else
        begin
            gather_reg <= gather_next;
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            rbp_reg    <= rbp_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

>>> hw/rtl/bpru_cmd_queue.sv
// Short command queue between front end and back end.
module bpru_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  bpru_pkg::cmd_t    wr_cmd,
    input  logic              rd_en,
    output bpru_pkg::cmd_t    rd_cmd,
    output logic              q_full,
    output logic              q_empty
);

    bpru_pkg::cmd_t                     slot_reg [bpru_pkg::CMD_DEPTH];
    logic [bpru_pkg::CMD_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bpru_pkg::CMD_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bpru_pkg::CMD_CNT_W-1:0]     count_reg, count_next;
    logic                               do_wr;
    logic                               do_rd;

    assign q_full  = count_reg == bpru_pkg::CMD_CNT_W'(bpru_pkg::CMD_DEPTH);
    assign q_empty = count_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == bpru_pkg::CMD_PTR_W'(bpru_pkg::CMD_DEPTH - 1))
                          ? '0 : wr_ptr_reg + bpru_pkg::CMD_PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == bpru_pkg::CMD_PTR_W'(bpru_pkg::CMD_DEPTH - 1))
                          ? '0 : rd_ptr_reg + bpru_pkg::CMD_PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + bpru_pkg::CMD_CNT_W'(1);
        else if (!do_wr && do_rd)
            count_next = count_reg - bpru_pkg::CMD_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/bpru_back.sv
// Back end: palette memory, per-pixel expansion, color decode and result queue.
module bpru_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bpru_pkg::cfg_t    cfg,
    input  bpru_pkg::cmd_t    q_cmd,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output bpru_pkg::result_t result
);

    logic [31:0]             pal_mem [bpru_pkg::PALETTE_DEPTH];
    logic [31:0]             pal_rdata_reg;

    bpru_pkg::cmd_t          cur_reg, cur_next;
    logic                    cur_valid_reg, cur_valid_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [7:0]              sh_reg, sh_next;

    logic                    b_valid_reg;
    logic                    b_pal_reg;
    logic                    b_inrange_reg;
    logic [31:0]             b_rgba_reg;
    logic                    b_row_end_reg;
    logic                    b_last_reg;

    bpru_pkg::result_t       of_slot_reg [bpru_pkg::OUT_DEPTH];
    logic [bpru_pkg::OUT_PTR_W-1:0] of_wr_reg, of_wr_next;
    logic [bpru_pkg::OUT_PTR_W-1:0] of_rd_reg, of_rd_next;
    logic [bpru_pkg::OUT_CNT_W-1:0] of_count_reg, of_count_next;

    logic                    is_wr;
    logic                    is_idx;
    logic                    credit_ok;
    logic                    issue;
    logic                    last_pix;
    logic                    load;
    logic [7:0]              pix_idx;
    logic                    idx_inrange;
    logic                    wr_inrange;
    logic [31:0]             rgba;
    logic [31:0]             b_color;
    logic                    of_push;
    logic                    of_pop;
    bpru_pkg::result_t       of_in;

    assign is_wr  = cur_reg.kind == bpru_pkg::K_PAL_WR;
    assign is_idx = (cur_reg.kind == bpru_pkg::K_IDX1) || (cur_reg.kind == bpru_pkg::K_IDX4)
                    || (cur_reg.kind == bpru_pkg::K_IDX8);

    assign credit_ok = ({1'b0, of_count_reg} + (bpru_pkg::OUT_CNT_W + 1)'(b_valid_reg))
                       < (bpru_pkg::OUT_CNT_W + 1)'(bpru_pkg::OUT_DEPTH);
    assign issue     = cur_valid_reg && (is_wr || credit_ok);
    assign last_pix  = is_wr || (cnt_reg == 4'd1);
    assign load      = (!cur_valid_reg || (issue && last_pix)) && !q_empty;
    assign q_pop     = load;

    always_comb
    begin
        case (cur_reg.kind)
            bpru_pkg::K_IDX1: pix_idx = {7'd0, sh_reg[7]};
            bpru_pkg::K_IDX4: pix_idx = {4'd0, sh_reg[7:4]};
            default:          pix_idx = sh_reg;
        endcase
    end

    assign idx_inrange = {1'b0, pix_idx} < 9'(bpru_pkg::PALETTE_DEPTH);
    assign wr_inrange  = {1'b0, cur_reg.index} < 9'(bpru_pkg::PALETTE_DEPTH);

    always_comb
    begin
        case (cur_reg.kind)
            bpru_pkg::K_RGB16:
                rgba = {cur_reg.data[14:10], 3'd0, cur_reg.data[9:5], 3'd0,
                        cur_reg.data[4:0], 3'd0, 8'hFF};
            bpru_pkg::K_RGB24:
                rgba = {cur_reg.data[23:16], cur_reg.data[15:8], cur_reg.data[7:0], 8'hFF};
            bpru_pkg::K_RGB32:
                rgba = {bpru_pkg::field_of(cur_reg.data, cfg.red_mask),
                        bpru_pkg::field_of(cur_reg.data, cfg.green_mask),
                        bpru_pkg::field_of(cur_reg.data, cfg.blue_mask),
                        bpru_pkg::field_of(cur_reg.data, cfg.alpha_mask)};
            default:
                rgba = '0;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        cnt_next       = cnt_reg;
        sh_next        = sh_reg;
        if (load)
        begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            cnt_next       = q_cmd.npix;
            sh_next        = q_cmd.data[7:0];
        end
        else if (issue)
        begin
            if (last_pix)
                cur_valid_next = 1'b0;
            cnt_next = cnt_reg - 4'd1;
            case (cur_reg.kind)
                bpru_pkg::K_IDX1: sh_next = {sh_reg[6:0], 1'b0};
                bpru_pkg::K_IDX4: sh_next = {sh_reg[3:0], 4'd0};
                default:          sh_next = sh_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && is_wr && wr_inrange)
            pal_mem[cur_reg.index[bpru_pkg::PAL_IDX_W-1:0]] <= cur_reg.data;
        pal_rdata_reg <= pal_mem[pix_idx[bpru_pkg::PAL_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        cnt_reg       <= cnt_next;
        sh_reg        <= sh_next;
        b_pal_reg     <= is_idx;
        b_inrange_reg <= idx_inrange;
        b_rgba_reg    <= rgba;
        b_row_end_reg <= last_pix && cur_reg.row_end;
        b_last_reg    <= last_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            b_valid_reg   <= issue && !is_wr;
        end
    end

    assign b_color = b_pal_reg ? (b_inrange_reg ? pal_rdata_reg : 32'd0) : b_rgba_reg;

    assign of_in.pixel_red   = b_color[31:24];
    assign of_in.pixel_green = b_color[23:16];
    assign of_in.pixel_blue  = b_color[15:8];
    assign of_in.pixel_alpha = b_color[7:0];
    assign of_in.row_end     = b_row_end_reg;
    assign of_in.last_of_run = b_last_reg;

    assign empty   = of_count_reg == '0;
    assign of_push = b_valid_reg;
    assign of_pop  = pop && !empty;
    assign result  = of_slot_reg[of_rd_reg];

    always_comb
    begin
        of_wr_next    = of_wr_reg;
        of_rd_next    = of_rd_reg;
        of_count_next = of_count_reg;
        if (of_push)
            of_wr_next = (of_wr_reg == bpru_pkg::OUT_PTR_W'(bpru_pkg::OUT_DEPTH - 1))
                         ? '0 : of_wr_reg + bpru_pkg::OUT_PTR_W'(1);
        if (of_pop)
            of_rd_next = (of_rd_reg == bpru_pkg::OUT_PTR_W'(bpru_pkg::OUT_DEPTH - 1))
                         ? '0 : of_rd_reg + bpru_pkg::OUT_PTR_W'(1);
        if (of_push && !of_pop)
            of_count_next = of_count_reg + bpru_pkg::OUT_CNT_W'(1);
        else if (!of_push && of_pop)
            of_count_next = of_count_reg - bpru_pkg::OUT_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (of_push)
            of_slot_reg[of_wr_reg] <= of_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            of_wr_reg    <= '0;
            of_rd_reg    <= '0;
            of_count_reg <= '0;
        end
        else
        begin
            of_wr_reg    <= of_wr_next;
            of_rd_reg    <= of_rd_next;
            of_count_reg <= of_count_next;
        end
    end

endmodule

>>> hw/rtl/bmp_pixel_row_unpacker_top.sv
// Top level of the BMP pixel row unpacker: config registers and front/back hookup.
// A pixel byte passes the command queue, current command and decode registers and
// the result queue. Throughput: one byte per cycle at 8, 16, 24 and 32 bpp while
// the queues have room; at 4 and 1 bpp the back end issues one pixel a cycle.
// Reset clears stream state and restores register defaults; palette contents
// stay undefined until loaded.
module bmp_pixel_row_unpacker_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bpru_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output bpru_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    bpru_pkg::cfg_t cfg_reg, cfg_next;
    logic           cmd_valid;
    bpru_pkg::cmd_t cmd;
    bpru_pkg::cmd_t q_cmd;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bpru_pkg::REG_BPP:        cfg_next.bits_per_pixel = cfg_data[5:0];
                bpru_pkg::REG_ROW_WIDTH:  cfg_next.row_width      = cfg_data[12:0];
                bpru_pkg::REG_RED_MASK:   cfg_next.red_mask       = cfg_data;
                bpru_pkg::REG_GREEN_MASK: cfg_next.green_mask     = cfg_data;
                bpru_pkg::REG_BLUE_MASK:  cfg_next.blue_mask      = cfg_data;
                bpru_pkg::REG_ALPHA_MASK: cfg_next.alpha_mask     = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bits_per_pixel <= 6'd8;
            cfg_reg.row_width      <= 13'd16;
            cfg_reg.red_mask       <= bpru_pkg::MASK_B2;
            cfg_reg.green_mask     <= bpru_pkg::MASK_B1;
            cfg_reg.blue_mask      <= 32'h000000FF;
            cfg_reg.alpha_mask     <= bpru_pkg::MASK_B3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpru_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    bpru_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_cmd  (cmd),
        .rd_en   (q_pop),
        .rd_cmd  (q_cmd),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    bpru_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_cmd   (q_cmd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> hw/rtl/bpru_checker.sv
// Port-level checks for the pixel row unpacker, bound to the top level.
`include "bmp_pixel_row_unpacker_top_defines.svh"

module bpru_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input bpru_pkg::result_t result
);

    // nothing waits on the result side while in reset
    `BPRU_ASSERT_ALWAYS(a_empty_in_reset, clk, !rst_n |-> empty)

    // a waiting result holds until its transfer
    `BPRU_ASSERT(a_result_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(result)))

    // a row always ends on the last pixel of its byte
    `BPRU_ASSERT(a_row_end_is_last, clk, rst_n, (!empty && result.row_end) |-> result.last_of_run)

endmodule

bind bmp_pixel_row_unpacker_top bpru_checker u_bpru_checker (.*);

>>> bench/bpru_pixel_checker.sv
// Scoreboard for the pixel row unpacker: tracks decode state and checks every pixel transfer.
module bpru_pixel_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  bpru_pkg::item_t   item,
    input  logic              empty,
    input  logic              pop,
    input  bpru_pkg::result_t result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output int                errors,
    output int                pending,
    output int                pixels_seen
);
    import bpru_pkg::*;

    logic [31:0] palette [PALETTE_DEPTH];
    logic [23:0] gather;
    logic [1:0]  gather_cnt;
    logic [12:0] column;
    logic [1:0]  row_bytes;
    logic [1:0]  pad_left;
    logic [5:0]  depth;
    logic [12:0] width;
    logic [31:0] red_m;
    logic [31:0] green_m;
    logic [31:0] blue_m;
    logic [31:0] alpha_m;
    result_t     expected_pixels [$];

    task automatic restart_stream();
        gather     = '0;
        gather_cnt = '0;
        column     = '0;
        row_bytes  = '0;
        pad_left   = '0;
    endtask

    function automatic logic [7:0] take_field(input logic [31:0] word, input logic [31:0] m);
        logic [31:0] wm;
        wm = word & m;
        if (m == MASK_B3)
            wm = wm >> 24;
        else if (m == MASK_B2)
            wm = wm >> 16;
        else if (m == MASK_B1)
            wm = wm >> 8;
        return wm[7:0];
    endfunction

    // Counts one pixel into the row; on the last one arms the padding skip.
    function automatic logic close_column();
        int w;
        w = (width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(width);
        if (w == 0)
            w = 1;
        if (int'(column) + 1 >= w)
        begin
            column    = '0;
            pad_left  = 2'd0 - row_bytes;
            row_bytes = '0;
            return 1'b1;
        end
        column = column + 13'd1;
        return 1'b0;
    endfunction

    task automatic unpack_item(input item_t it);
        result_t     px;
        logic [31:0] entry;
        logic [31:0] word;
        logic [31:0] lowmask;
        logic [7:0]  idx;
        logic        row_done;
        int          per;
        int          need;
        int          p;
        if (it.opcode == OP_PAL_LOAD)
        begin
            palette[it.entry_index] = {it.entry_red, it.entry_green, it.entry_blue,
                                       it.entry_alpha};
            return;
        end
        if (it.opcode == OP_NEW_IMAGE)
        begin
            restart_stream();
            return;
        end
        if (it.opcode != OP_PIXEL)
            return;
        if (!(depth == 6'd1 || depth == 6'd4 || depth == 6'd8 || depth == 6'd16 ||
              depth == 6'd24 || depth == 6'd32))
            return;
        if (pad_left != 2'd0)
        begin
            pad_left = pad_left - 2'd1;
            return;
        end
        row_bytes = row_bytes + 2'd1;
        if (depth <= 6'd8)
        begin
            per = 8 / depth;
            for (p = 0; p < per; p++)
            begin
                idx      = 8'((it.data_byte >> (8 - depth * (p + 1))) & ((1 << depth) - 1));
                entry    = palette[idx];
                row_done = close_column();
                px             = '0;
                px.pixel_red   = entry[31:24];
                px.pixel_green = entry[23:16];
                px.pixel_blue  = entry[15:8];
                px.pixel_alpha = entry[7:0];
                px.row_end     = row_done;
                px.last_of_run = row_done || (p == per - 1);
                expected_pixels.push_back(px);
                if (row_done)
                    break;
            end
        end
        else
        begin
            need = depth / 8;
            if (gather_cnt + 1 < need)
            begin
                gather     = gather | (24'(it.data_byte) << (8 * gather_cnt));
                gather_cnt = gather_cnt + 2'd1;
                return;
            end
            lowmask    = (32'd1 << (8 * (need - 1))) - 32'd1;
            word       = ({8'h00, gather} & lowmask) | (32'(it.data_byte) << (8 * (need - 1)));
            gather     = '0;
            gather_cnt = '0;
            px = '0;
            if (depth == 6'd16)
            begin
                px.pixel_red   = {word[14:10], 3'b000};
                px.pixel_green = {word[9:5], 3'b000};
                px.pixel_blue  = {word[4:0], 3'b000};
                px.pixel_alpha = 8'hFF;
            end
            else if (depth == 6'd24)
            begin
                px.pixel_red   = word[23:16];
                px.pixel_green = word[15:8];
                px.pixel_blue  = word[7:0];
                px.pixel_alpha = 8'hFF;
            end
            else
            begin
                px.pixel_red   = take_field(word, red_m);
                px.pixel_green = take_field(word, green_m);
                px.pixel_blue  = take_field(word, blue_m);
                px.pixel_alpha = take_field(word, alpha_m);
            end
            px.row_end     = close_column();
            px.last_of_run = 1'b1;
            expected_pixels.push_back(px);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    bad;
        if (!rst_n)
        begin
            restart_stream();
            depth       = 6'd8;
            width       = 13'd16;
            red_m       = MASK_B2;
            green_m     = MASK_B1;
            blue_m      = 32'h0000_00FF;
            alpha_m     = MASK_B3;
            expected_pixels.delete();
            errors      = 0;
            pending     = 0;
            pixels_seen = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pixel: %h %h %h %h end %b last %b",
                                 result.pixel_red, result.pixel_green, result.pixel_blue,
                                 result.pixel_alpha, result.row_end, result.last_of_run);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_seen++;
                    bad = (result.pixel_red !== want.pixel_red) ||
                          (result.pixel_green !== want.pixel_green) ||
                          (result.pixel_blue !== want.pixel_blue) ||
                          (result.pixel_alpha !== want.pixel_alpha) ||
                          (result.row_end !== want.row_end) ||
                          (result.last_of_run !== want.last_of_run);
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"pixel %0d mismatch: expected %h %h %h %h end %b last %b,",
                                      " got %h %h %h %h end %b last %b"},
                                     pixels_seen, want.pixel_red, want.pixel_green,
                                     want.pixel_blue, want.pixel_alpha, want.row_end,
                                     want.last_of_run, result.pixel_red, result.pixel_green,
                                     result.pixel_blue, result.pixel_alpha, result.row_end,
                                     result.last_of_run);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BPP:        depth   = cfg_data[5:0];
                    REG_ROW_WIDTH:  width   = cfg_data[12:0];
                    REG_RED_MASK:   red_m   = cfg_data;
                    REG_GREEN_MASK: green_m = cfg_data;
                    REG_BLUE_MASK:  blue_m  = cfg_data;
                    REG_ALPHA_MASK: alpha_m = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                unpack_item(item);
            pending = expected_pixels.size();
        end
    end

endmodule

>>> bench/bmp_pixel_row_unpacker_top_test.sv
// Testbench top for the pixel row unpacker: stimulus, idle bursts, watchdog and verdict.
module bmp_pixel_row_unpacker_top_test;
    import bpru_pkg::*;

    localparam logic [1:0] OP_RESERVED    = 2'd3;
    localparam logic [2:0] REG_UNMAPPED   = 3'd7;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         RANDOM_PHASES  = 7;
    localparam int         PHASE_ITEMS    = 12;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    item_t       item;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          pixels_seen;
    bit          loaded [PALETTE_DEPTH];
    bit          idling;
    logic [5:0]  cur_bpp;
    int          items_sent;
    int          stall_run;

    bmp_pixel_row_unpacker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bpru_pixel_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .pixels_seen (pixels_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic item_t noisy_item(input logic [1:0] op, input logic [7:0] data);
        logic [63:0] noise;
        item_t       it;
        noise = {$urandom, $urandom};
        it = noise[$bits(item_t)-1:0];
        it.opcode    = op;
        it.data_byte = data;
        return it;
    endfunction

    // Only palette slots already loaded may be looked up.
    function automatic logic [7:0] pick_slot(input int top);
        int s;
        do
            s = $urandom_range(top, 0);
        while (!loaded[s]);
        return 8'(s);
    endfunction

    function automatic logic [7:0] random_pixel_byte();
        logic [7:0] hi;
        logic [7:0] lo;
        case (cur_bpp)
            6'd4:
            begin
                hi = pick_slot(15);
                lo = pick_slot(15);
                return {hi[3:0], lo[3:0]};
            end
            6'd8:    return pick_slot(255);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] pick_depth();
        case ($urandom_range(9, 0))
            0:       return 6'd1;
            1:       return 6'd4;
            2, 7:    return 6'd8;
            3, 8:    return 6'd16;
            4:       return 6'd24;
            5, 6:    return 6'd32;
            default: return 6'($urandom_range(63, 0));
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(7, 0))
            0:       return MASK_B3;
            1:       return MASK_B2;
            2:       return MASK_B1;
            3:       return 32'h0000_00FF;
            4:       return 32'h0000_0000;
            5:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input item_t it);
        if (idling && $urandom_range(3, 0) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(17, 1)) @(negedge clk);
        end
        push = 1'b1;
        item = it;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(noisy_item(OP_PIXEL, b));
    endtask

    task automatic load_entry(input logic [7:0] slot, input logic [31:0] rgba);
        item_t it;
        it = noisy_item(OP_PAL_LOAD, 8'($urandom));
        it.entry_index = slot;
        {it.entry_red, it.entry_green, it.entry_blue, it.entry_alpha} = rgba;
        loaded[slot] = 1'b1;
        send_item(it);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic [5:0] bpp, input logic [12:0] w);
        wait_idle();
        cur_bpp = bpp;
        write_reg(REG_BPP, 32'(bpp));
        write_reg(REG_ROW_WIDTH, 32'(w));
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(5, 0) == 0)
            begin
                pop = 1'b0;
                repeat ($urandom_range(17, 1)) @(negedge clk);
            end
            pop = 1'b1;
        end
    end

    // Watchdog: no transfer on any channel for too long.
    initial
    begin
        stall_run = 0;
        while (stall_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_run = 0;
            else
                stall_run++;
        end
        $display("bmp_pixel_row_unpacker_top_test: done, errors");
        $finish;
    end

    initial
    begin
        int          phase;
        int          k;
        int          roll;
        logic [31:0] w;
        rst_n      = 1'b0;
        push       = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_BPP;
        cfg_data   = '0;
        idling     = 1'b1;
        cur_bpp    = 6'd8;
        items_sent = 0;
        foreach (loaded[i])
            loaded[i] = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: palette extremes, each depth, padding, reserved opcode
        load_entry(8'd0, 32'h0000_0000);
        load_entry(8'd1, 32'hFFFF_FFFF);
        load_entry(8'd15, $urandom);
        load_entry(8'd255, 32'hA55A_C33C);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0F);
        send_item(noisy_item(OP_RESERVED, 8'($urandom)));
        send_item(noisy_item(OP_NEW_IMAGE, 8'($urandom)));
        set_mode(6'd1, 13'd3);
        send_byte(8'hA5);
        send_byte(8'hFF);
        send_byte(8'h5A);
        set_mode(6'd4, 13'd1);
        send_item(noisy_item(OP_NEW_IMAGE, 8'($urandom)));
        send_byte(8'h1F);
        set_mode(6'd16, 13'd16);
        send_item(noisy_item(OP_NEW_IMAGE, 8'($urandom)));
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h80);
        set_mode(6'd24, 13'd2);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        set_mode(6'd32, 13'd5);
        repeat (4) send_byte(8'($urandom));
        set_mode(6'd63, 13'd16);
        send_byte(8'($urandom));

        // random phases; each starts from an idle block (sender holds until drained)
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idling = (phase < RANDOM_PHASES - 2);
            wait_idle();
            cur_bpp = pick_depth();
            write_reg(REG_BPP, ($urandom & ~32'h3F) | 32'(cur_bpp));
            case (phase)
                0:       w = 32'd0;
                1:       w = 32'd8191;
                2:       w = 32'd4096;
                default: w = $urandom_range(9, 1);
            endcase
            write_reg(REG_ROW_WIDTH, ($urandom & ~32'h1FFF) | w);
            if (phase == 0 || $urandom_range(2, 0) == 0)
                write_reg(REG_RED_MASK, pick_mask());
            if (phase == 0 || $urandom_range(2, 0) == 0)
                write_reg(REG_GREEN_MASK, pick_mask());
            if (phase == 0 || $urandom_range(2, 0) == 0)
                write_reg(REG_BLUE_MASK, pick_mask());
            if (phase == 0 || $urandom_range(2, 0) == 0)
                write_reg(REG_ALPHA_MASK, pick_mask());
            if (phase == 3)
                write_reg(REG_UNMAPPED, $urandom);
            cfg_valid = 1'b0;
            if ($urandom_range(1, 0) == 1)
                send_item(noisy_item(OP_NEW_IMAGE, 8'($urandom)));
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 8)
                    load_entry(8'($urandom), $urandom);
                else if (roll < 11)
                    send_item(noisy_item(OP_NEW_IMAGE, 8'($urandom)));
                else if (roll < 13)
                    send_item(noisy_item(OP_RESERVED, 8'($urandom)));
                else
                    send_byte(random_pixel_byte());
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("summary: %0d input transfers, %0d pixel transfers checked",
                 items_sent, pixels_seen);
        $display("summary: depths 1-32 plus unsupported, widths 0-8191, masks, padding");
        if (errors == 0 && pending == 0)
            $display("bmp_pixel_row_unpacker_top_test: done, clean");
        else
            $display("bmp_pixel_row_unpacker_top_test: done, errors");
        $finish;
    end

endmodule
